// ===== rtl/core/qpvs_pkg.sv =====
package qpvs_pkg;

    // byte codes that steer the splitter
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_FF     = 8'h0C;

    // result kinds
    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_MARKER = 1'b1;

    localparam int DEPTH_LIMIT_DEFAULT = 127;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // up to two results caused by one item
    typedef struct packed {
        logic       first_valid;
        logic       first_kind;
        logic [7:0] first_byte;
        logic       end_marker;
    } bundle_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_CR) || (c == CH_FF);
    endfunction

endpackage

// ===== rtl/core/qpvs_in_if.sv =====
interface qpvs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       byte_present;
    logic       end_of_value;

    modport source (output valid, output char_byte, output byte_present,
                    output end_of_value, input ready);
    modport sink (input valid, input char_byte, input byte_present,
                  input end_of_value, output ready);
endinterface

// ===== rtl/core/qpvs_out_if.sv =====
interface qpvs_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] token_byte;
    logic       last_of_run;

    modport source (output valid, output kind, output token_byte,
                    output last_of_run, input ready);
    modport sink (input valid, input kind, input token_byte,
                  input last_of_run, output ready);
endinterface

// ===== rtl/core/quote_paren_aware_value_splitter.sv =====
// quote- and parenthesis-aware value splitter
//
// value channel: one byte of the value text per item (char_byte), with
// byte_present low for an item that only flushes and end_of_value high on
// the last item of a value. tokens channel: token bytes (kind 0) and
// end-of-token markers (kind 1, token_byte 0); last_of_run flags the final
// result that an input item produced. whitespace outside quotes and parens
// splits tokens; quotes and parens stay in the token, but a ')' with no token open is dropped.
//
// the first result of an item is written into the queue and then loaded into
// the output register. throughput: one item per cycle while the queue is not
// full and each item gives at most one result; the output register sends one
// result per cycle while the receiver is ready, so an item with a byte and an
// end marker holds the back end for both. the QUEUE_DEPTH-entry queue absorbs that.
//
// reset clears depth, quote and token state, the queue and the output
// register. when the receiver stalls, the output holds, the queue fills and
// value.ready drops only once the queue is full.
module quote_paren_aware_value_splitter #(
    parameter int DEPTH_LIMIT = qpvs_pkg::DEPTH_LIMIT_DEFAULT,
    parameter int QUEUE_DEPTH = qpvs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    qpvs_in_if.sink     value,
    qpvs_out_if.source  tokens
);

    // front to queue
    logic                push;
    qpvs_pkg::bundle_t   push_data;
    // queue to back
    logic                pop;
    qpvs_pkg::bundle_t   head_data;
    qpvs_pkg::q_status_t q_status;

    // front: classifies each byte and tracks depth, quote and token state
    qpvs_front #(
        .DEPTH_LIMIT (DEPTH_LIMIT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    // short queue of result bundles, one bundle per item that gives results
    qpvs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .q_status  (q_status)
    );

    // back: unpacks each bundle into one or two results
    qpvs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_data (head_data),
        .q_status  (q_status),
        .pop       (pop),
        .tokens    (tokens)
    );

    // front never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_status.full))
        else $error("push into full queue");

    // back never pops an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && q_status.empty))
        else $error("pop from empty queue");

    // every bundle in the queue carries at least one result
    a_bundle_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (push_data.first_valid || push_data.end_marker))
        else $error("empty bundle pushed");

    // an end marker carries a zero byte
    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (tokens.valid && tokens.kind == qpvs_pkg::KIND_MARKER) |-> tokens.token_byte == 8'h00)
        else $error("end marker with nonzero byte");

endmodule

// ===== rtl/core/qpvs_front.sv =====
module qpvs_front #(
    parameter int DEPTH_LIMIT = qpvs_pkg::DEPTH_LIMIT_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    qpvs_in_if.sink              value,
    input  qpvs_pkg::q_status_t  q_status,
    output logic                 push,
    output qpvs_pkg::bundle_t    push_data
);

    localparam int DW = $clog2(DEPTH_LIMIT + 1) + 1;
    localparam logic signed [DW-1:0] LIM_POS = DW'(DEPTH_LIMIT);
    localparam logic signed [DW-1:0] LIM_NEG = -DW'(DEPTH_LIMIT);

    logic signed [DW-1:0] depth_reg, depth_next;
    logic quote_active_reg, quote_active_next;
    logic quote_single_reg, quote_single_next;
    logic token_open_reg, token_open_next;

    logic       accept;
    logic       emit;
    logic       closes;
    logic [7:0] c;

    assign value.ready = !q_status.full;
    assign accept      = value.valid && value.ready;
    assign c           = value.char_byte;

    always_comb
    begin
        depth_next        = depth_reg;
        quote_active_next = quote_active_reg;
        quote_single_next = quote_single_reg;
        token_open_next   = token_open_reg;
        emit              = 1'b0;
        closes            = 1'b0;

        if (value.byte_present)
        begin
            priority if (!quote_active_reg &&
                         (c == qpvs_pkg::CH_DQUOTE || c == qpvs_pkg::CH_SQUOTE))
            begin
                quote_active_next = 1'b1;
                quote_single_next = (c == qpvs_pkg::CH_SQUOTE);
                emit              = 1'b1;
            end
            else if (quote_active_reg &&
                     c == (quote_single_reg ? qpvs_pkg::CH_SQUOTE : qpvs_pkg::CH_DQUOTE))
            begin
                quote_active_next = 1'b0;
                emit              = 1'b1;
            end
            else if (!quote_active_reg && c == qpvs_pkg::CH_LPAREN)
            begin
                if (depth_reg < LIM_POS)
                    depth_next = depth_reg + DW'(1);
                emit = 1'b1;
            end
            else if (!quote_active_reg && c == qpvs_pkg::CH_RPAREN)
            begin
                if (depth_reg > LIM_NEG)
                    depth_next = depth_reg - DW'(1);
                emit = token_open_reg;
            end
            else if (!quote_active_reg && qpvs_pkg::is_space(c) && depth_reg == '0)
            begin
                closes = token_open_reg;
            end
            else
            begin
                emit = 1'b1;
            end

            if (emit)
                token_open_next = 1'b1;
            else if (closes)
                token_open_next = 1'b0;
        end

        push_data.first_valid = emit || closes;
        push_data.first_kind  = emit ? qpvs_pkg::KIND_BYTE : qpvs_pkg::KIND_MARKER;
        push_data.first_byte  = emit ? c : 8'h00;
        push_data.end_marker  = value.end_of_value && token_open_next;

        // end of value wipes all state
        if (value.end_of_value)
        begin
            depth_next        = '0;
            quote_active_next = 1'b0;
            quote_single_next = 1'b0;
            token_open_next   = 1'b0;
        end

        push = accept && (push_data.first_valid || push_data.end_marker);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg        <= '0;
            quote_active_reg <= 1'b0;
            quote_single_reg <= 1'b0;
            token_open_reg   <= 1'b0;
        end
        else if (accept)
        begin
            depth_reg        <= depth_next;
            quote_active_reg <= quote_active_next;
            quote_single_reg <= quote_single_next;
            token_open_reg   <= token_open_next;
        end
    end

endmodule

// ===== rtl/core/qpvs_queue.sv =====
module qpvs_queue #(
    parameter int DEPTH = qpvs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  qpvs_pkg::bundle_t   push_data,
    input  logic                pop,
    output qpvs_pkg::bundle_t   head_data,
    output qpvs_pkg::q_status_t q_status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    qpvs_pkg::bundle_t mem [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign q_status.empty = (count_reg == '0);
    assign q_status.full  = (count_reg == CW'(DEPTH));
    assign head_data      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== rtl/core/qpvs_back.sv =====
module qpvs_back (
    input  logic                clk,
    input  logic                rst_n,
    input  qpvs_pkg::bundle_t   head_data,
    input  qpvs_pkg::q_status_t q_status,
    output logic                pop,
    qpvs_out_if.source          tokens
);

    logic       valid_reg, valid_next;
    logic       kind_reg, kind_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    // set once the first result of the head bundle is loaded while its end marker remains
    logic       phase_reg, phase_next;
    logic       load;

    assign tokens.valid       = valid_reg;
    assign tokens.kind        = kind_reg;
    assign tokens.token_byte  = byte_reg;
    assign tokens.last_of_run = last_reg;

    always_comb
    begin
        load       = (!valid_reg || tokens.ready) && !q_status.empty;
        valid_next = valid_reg;
        kind_next  = kind_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        phase_next = phase_reg;
        pop        = 1'b0;

        if (!valid_reg || tokens.ready)
            valid_next = 1'b0;

        if (load)
        begin
            valid_next = 1'b1;
            if (!phase_reg && head_data.first_valid)
            begin
                kind_next = head_data.first_kind;
                byte_next = head_data.first_byte;
                last_next = !head_data.end_marker;
                if (head_data.end_marker)
                    phase_next = 1'b1;
                else
                    pop = 1'b1;
            end
            else
            begin
                kind_next  = qpvs_pkg::KIND_MARKER;
                byte_next  = 8'h00;
                last_next  = 1'b1;
                phase_next = 1'b0;
                pop        = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

endmodule
